FILE: rtl/core/hidl_pkg.sv
`timescale 1ns / 1ps

package hidl_pkg;

  localparam int DEPTH_DEF  = 65536;
  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int COEF_W     = 28;
  localparam int ACC_W      = 48;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;
  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] OFF_M1 = 2'd0;
  localparam logic [1:0] OFF_0  = 2'd1;
  localparam logic [1:0] OFF_P1 = 2'd2;
  localparam logic [1:0] OFF_P2 = 2'd3;

  localparam logic [1:0] SEL_D0 = 2'd0;
  localparam logic [1:0] SEL_D1 = 2'd1;
  localparam logic [1:0] SEL_D2 = 2'd2;

  typedef struct packed {
    logic       clr_en;
    logic       wr_sample;
    logic       latch;
    logic       rd_en;
    logic [1:0] rd_off;
    logic       shift;
    logic       coef_load;
    logic       mul;
    logic       add;
    logic [1:0] coef_sel;
    logic       out_load;
  } hidl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } hidl_sts_t;

endpackage

FILE: rtl/core/hermite_interpolated_delay_line.sv
`timescale 1ns / 1ps
// A write beat is stored at its accept edge; it gives no result.
// A read beat passes in order through four reads of the single memory read port,
// a shift of the last sample, a coefficient load, a multiply and an add for each
// of the three Horner steps, and a step that saturates and registers the result.
// No new beat is taken until a read is done, longer while an earlier result waits; a write does not hold the block.
// After reset every entry of the sample memory is cleared, one entry a cycle, with in_tready low.

module hermite_interpolated_delay_line
  import hidl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // position_int, position_frac, write_sample
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_sample
  output logic [OUT_DATA_W-1:0] out_tdata
);

  hidl_cmd_t cmd;
  hidl_sts_t sts;

  hidl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hidl_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

FILE: rtl/core/hidl_ctrl.sv
`timescale 1ns / 1ps

module hidl_ctrl
  import hidl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tuser,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  hidl_sts_t sts,
  output hidl_cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD0   = 4'd2;
  localparam logic [3:0] ST_RD1   = 4'd3;
  localparam logic [3:0] ST_RD2   = 4'd4;
  localparam logic [3:0] ST_RD3   = 4'd5;
  localparam logic [3:0] ST_RD4   = 4'd6;
  localparam logic [3:0] ST_COEF  = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_ADD   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_WRITE) begin
            cmd.wr_sample = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_nxt = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_M1;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_0;
        cmd.shift  = 1'b1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_P1;
        cmd.shift  = 1'b1;
        state_nxt  = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_P2;
        cmd.shift  = 1'b1;
        state_nxt  = ST_RD4;
      end
      ST_RD4: begin
        cmd.shift = 1'b1;
        state_nxt = ST_COEF;
      end
      ST_COEF: begin
        cmd.coef_load = 1'b1;
        step_nxt      = SEL_D2;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add      = 1'b1;
        cmd.coef_sel = step_r;
        if (step_r == SEL_D0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt  = step_r - 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= SEL_D2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/hidl_datapath.sv
`timescale 1ns / 1ps

module hidl_datapath
  import hidl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  hidl_cmd_t             cmd,
  output hidl_sts_t             sts,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HALF_W = ACC_W / 2;
  localparam int PH_W   = HALF_W + FRAC_W + 1;
  localparam int PL_W   = HALF_W + FRAC_W;
  localparam int PROD_W = ACC_W + FRAC_W + 2;
  localparam int RQ_W   = ACC_W - 17;
  localparam logic [31:0] MASK = 32'(DEPTH - 1);
  localparam logic signed [RQ_W-1:0] RQ_MAX = RQ_W'(SAMPLE_MAX);
  localparam logic signed [RQ_W-1:0] RQ_MIN = RQ_W'(SAMPLE_MIN);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [AW-1:0]       clr_cnt_r;
  logic [POS_W-1:0]    pos_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic signed [SAMPLE_W-1:0] s0_r, s1_r, s2_r, s3_r;
  logic signed [COEF_W-1:0]   d0_r, d1_r, d2_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [PH_W-1:0]     ph_r;
  logic [PL_W-1:0]            pl_r;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  logic [POS_W-1:0]    in_pos;
  logic [SAMPLE_W-1:0] in_sample;
  logic [31:0]         wr_full, rd_full;
  logic [AW-1:0]       wr_addr, rd_addr, mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_wen;

  logic signed [COEF_W-1:0] e0, e1, e2, e3, d3, d2, d1, d0, dk;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [RQ_W-1:0]   rq;

  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_sample = in_tdata[POS_W+FRAC_W+SAMPLE_W-1:POS_W+FRAC_W];

  assign wr_full = 32'(in_pos) & MASK;
  assign rd_full = (32'(pos_r) + 32'(cmd.rd_off) - 32'd1) & MASK;
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  assign mem_wen   = cmd.clr_en | cmd.wr_sample;
  assign mem_waddr = cmd.clr_en ? clr_cnt_r : wr_addr;
  assign mem_wdata = cmd.clr_en ? '0 : in_sample;

  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (mem_wen) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && !sts.clr_last) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign e0 = COEF_W'(s0_r);
  assign e1 = COEF_W'(s1_r);
  assign e2 = COEF_W'(s2_r);
  assign e3 = COEF_W'(s3_r);

  assign d0 = e1 <<< 1;
  assign d1 = e2 - e0;
  assign d2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign d3 = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);

  always_comb begin
    case (cmd.coef_sel)
      SEL_D0:  dk = d0_r;
      SEL_D1:  dk = d1_r;
      SEL_D2:  dk = d2_r;
      default: dk = d0_r;
    endcase
  end

  assign prod    = (PROD_W'(ph_r) <<< HALF_W) + PROD_W'($signed({1'b0, pl_r}));
  assign prod_sh = prod >>> FRAC_W;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.coef_load) begin
      acc_nxt = ACC_W'(d3) <<< 16;
    end else if (cmd.add) begin
      acc_nxt = prod_sh[ACC_W-1:0] + (ACC_W'(dk) <<< 16);
    end
  end

  assign rsum = acc_r + ACC_W'(65536);
  assign rq   = $signed(rsum[ACC_W-1:17]);

  always_comb begin
    if (rq > RQ_MAX) begin
      out_data_nxt = OUT_DATA_W'(SAMPLE_MAX);
    end else if (rq < RQ_MIN) begin
      out_data_nxt = OUT_DATA_W'(SAMPLE_MIN);
    end else begin
      out_data_nxt = rq[OUT_DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos_r  <= in_pos;
      frac_r <= in_tdata[POS_W+FRAC_W-1:POS_W];
    end
    if (cmd.shift) begin
      s0_r <= s1_r;
      s1_r <= s2_r;
      s2_r <= s3_r;
      s3_r <= $signed(rdata_r);
    end
    if (cmd.coef_load) begin
      d0_r <= d0;
      d1_r <= d1;
      d2_r <= d2;
    end
    if (cmd.mul) begin
      ph_r <= $signed(acc_r[ACC_W-1:HALF_W]) * $signed({1'b0, frac_r});
      pl_r <= acc_r[HALF_W-1:0] * frac_r;
    end
    acc_r <= acc_nxt;
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

endmodule

FILE: rtl/core/hidl_checker.sv
`timescale 1ns / 1ps

module hidl_checker
  import hidl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("write beat produced a result");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_READ |=> !in_tready)
    else $error("input taken while a read is in progress");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a read in progress");

endmodule

bind hermite_interpolated_delay_line hidl_checker u_hidl_checker (.*);
